// ----- rtl/lldq_pkg.sv -----
package lldq_pkg;

  // request codes
  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_TAIL  = 3'd1;
  localparam logic [2:0] ACT_RM_FIRST  = 3'd2;
  localparam logic [2:0] ACT_RM_LAST   = 3'd3;
  localparam logic [2:0] ACT_RM_VALUE  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_INS_RD,
    S_INS_LINK,
    S_RM_RD,
    S_WALK,
    S_UNL,
    S_FINISH
  } lldq_state_t;

  // write enables of the three node arrays
  typedef struct packed {
    logic val;
    logic nxt;
    logic prv;
  } lldq_we_t;

endpackage

// ----- rtl/linked_list_deque_engine.sv -----
// Per request: insert runs S_POP (only to reuse a freed node), S_INS_RD, S_INS_LINK
//   (skipped into an empty list), S_FINISH; remove first/last runs S_RM_RD, S_UNL,
//   S_FINISH; remove by value walks nodes in S_WALK, then S_UNL on a hit or S_FINISH on
//   a miss; full, empty or undefined requests go straight to S_FINISH. One request at a
//   time, the next taken once the word is registered. Reset clears the sequencer, tail,
//   count and free-list pointers; node and free-stack memories get no clearing pass.
module linked_list_deque_engine import lldq_pkg::*; #(
  parameter int NODE_COUNT = 64,
  localparam int IDX_W = $clog2(NODE_COUNT),
  localparam int CNT_W = $clog2(NODE_COUNT + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_removed_value,
  output logic [CNT_W-1:0]   out_entry_count
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NODE_COUNT);

  lldq_state_t state_r, state_nxt;

  logic [2:0]         act_r, act_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   fresh_r, fresh_nxt;
  logic [CNT_W-1:0]   stk_top_r, stk_top_nxt;
  logic [IDX_W-1:0]   node_r, node_nxt;
  logic [IDX_W-1:0]   first_r, first_nxt;
  logic [IDX_W-1:0]   cur_r, cur_nxt;
  logic [IDX_W-1:0]   tgt_r, tgt_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic signed [31:0] res_removed_r, res_removed_nxt;

  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_removed_r;
  logic [CNT_W-1:0]   out_count_r;

  // node memory port
  lldq_we_t           we;
  logic [IDX_W-1:0]   wr_val_addr, wr_nxt_addr, wr_nxt, wr_prv_addr, wr_prv;
  logic [IDX_W-1:0]   rd_addr;
  logic signed [31:0] rd_val;
  logic [IDX_W-1:0]   rd_nxt, rd_prv;

  // free stack of recycled nodes; never-used nodes come from fresh_r
  logic [IDX_W-1:0]   stk_mem [NODE_COUNT];
  logic               stk_we;
  logic [IDX_W-1:0]   stk_wr_addr, stk_rd_addr, stk_rdata;
  logic [CNT_W-1:0]   stk_dec, k_inc;

  logic out_free, hit, last_node;

  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign stk_dec   = stk_top_r - 1'b1;
  assign k_inc     = k_r + 1'b1;
  assign hit       = (rd_val == val_r);
  assign last_node = (k_inc == count_r);

  lldq_node_mem #(.DEPTH(NODE_COUNT)) u_mem (
    .clk         (clk),
    .we          (we),
    .wr_val_addr (wr_val_addr),
    .wr_val      (val_r),
    .wr_nxt_addr (wr_nxt_addr),
    .wr_nxt      (wr_nxt),
    .wr_prv_addr (wr_prv_addr),
    .wr_prv      (wr_prv),
    .rd_addr     (rd_addr),
    .rd_val      (rd_val),
    .rd_nxt      (rd_nxt),
    .rd_prv      (rd_prv)
  );

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wr_addr] <= tgt_r;
    end
    stk_rdata <= stk_mem[stk_rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_INS_FRONT, ACT_INS_TAIL: begin
              if (count_r == FULL_CNT) begin
                state_nxt = S_FINISH;
              end else if (stk_top_r != '0) begin
                state_nxt = S_POP;
              end else begin
                state_nxt = S_INS_RD;
              end
            end
            ACT_RM_FIRST, ACT_RM_LAST, ACT_RM_VALUE: begin
              state_nxt = (count_r == '0) ? S_FINISH : S_RM_RD;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end
      S_POP:      state_nxt = S_INS_RD;
      S_INS_RD:   state_nxt = (count_r == '0) ? S_FINISH : S_INS_LINK;
      S_INS_LINK: state_nxt = S_FINISH;
      S_RM_RD:    state_nxt = (act_r == ACT_RM_VALUE) ? S_WALK : S_UNL;
      S_WALK: begin
        if (hit) begin
          state_nxt = S_UNL;
        end else if (last_node) begin
          state_nxt = S_FINISH;
        end
      end
      S_UNL:      state_nxt = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    act_nxt         = act_r;
    val_nxt         = val_r;
    tail_nxt        = tail_r;
    count_nxt       = count_r;
    fresh_nxt       = fresh_r;
    stk_top_nxt     = stk_top_r;
    node_nxt        = node_r;
    first_nxt       = first_r;
    cur_nxt         = cur_r;
    tgt_nxt         = tgt_r;
    k_nxt           = k_r;
    res_status_nxt  = res_status_r;
    res_removed_nxt = res_removed_r;
    we              = '0;
    wr_val_addr     = node_r;
    wr_nxt_addr     = node_r;
    wr_nxt          = node_r;
    wr_prv_addr     = node_r;
    wr_prv          = node_r;
    rd_addr         = tail_r;
    stk_we          = 1'b0;
    stk_wr_addr     = stk_top_r[IDX_W-1:0];
    stk_rd_addr     = stk_dec[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt         = in_action;
          val_nxt         = in_value;
          res_status_nxt  = ST_DONE;
          res_removed_nxt = '0;
          case (in_action)
            ACT_INS_FRONT, ACT_INS_TAIL: begin
              if (count_r == FULL_CNT) begin
                res_status_nxt = ST_FULL;
              end else if (stk_top_r == '0) begin
                node_nxt  = fresh_r[IDX_W-1:0];
                fresh_nxt = fresh_r + 1'b1;
              end
            end
            ACT_RM_FIRST, ACT_RM_LAST, ACT_RM_VALUE: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        node_nxt    = stk_rdata;
        stk_top_nxt = stk_dec;
      end
      S_INS_RD: begin
        // rd_nxt holds the first node (forward link of the tail)
        we.val = 1'b1;
        if (count_r == '0) begin
          we.nxt    = 1'b1;
          we.prv    = 1'b1;
          tail_nxt  = node_r;
          count_nxt = count_r + 1'b1;
        end else begin
          we.nxt      = 1'b1;
          wr_nxt_addr = tail_r;
          we.prv      = 1'b1;
          wr_prv      = tail_r;
          first_nxt   = rd_nxt;
        end
      end
      S_INS_LINK: begin
        we.nxt      = 1'b1;
        wr_nxt      = first_r;
        we.prv      = 1'b1;
        wr_prv_addr = first_r;
        if (act_r == ACT_INS_TAIL) begin
          tail_nxt = node_r;
        end
        count_nxt = count_r + 1'b1;
      end
      S_RM_RD: begin
        tgt_nxt = (act_r == ACT_RM_LAST) ? tail_r : rd_nxt;
        rd_addr = tgt_nxt;
        cur_nxt = rd_nxt;
        k_nxt   = '0;
      end
      S_WALK: begin
        if (hit) begin
          tgt_nxt = cur_r;
          rd_addr = cur_r;
        end else if (last_node) begin
          res_status_nxt = ST_NOT_FOUND;
        end else begin
          cur_nxt = rd_nxt;
          rd_addr = rd_nxt;
          k_nxt   = k_inc;
        end
      end
      S_UNL: begin
        res_removed_nxt = rd_val;
        stk_we          = 1'b1;
        stk_top_nxt     = stk_top_r + 1'b1;
        if (count_r == CNT_W'(1)) begin
          count_nxt = '0;
        end else begin
          we.nxt      = 1'b1;
          wr_nxt_addr = rd_prv;
          wr_nxt      = rd_nxt;
          we.prv      = 1'b1;
          wr_prv_addr = rd_nxt;
          wr_prv      = rd_prv;
          if (tgt_r == tail_r) begin
            tail_nxt = rd_prv;
          end
          count_nxt = count_r - 1'b1;
        end
      end
      S_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tail_r      <= '0;
      count_r     <= '0;
      fresh_r     <= '0;
      stk_top_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      fresh_r   <= fresh_nxt;
      stk_top_r <= stk_top_nxt;
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    val_r         <= val_nxt;
    node_r        <= node_nxt;
    first_r       <= first_nxt;
    cur_r         <= cur_nxt;
    tgt_r         <= tgt_nxt;
    k_r           <= k_nxt;
    res_status_r  <= res_status_nxt;
    res_removed_r <= res_removed_nxt;
    if (state_r == S_FINISH && out_free) begin
      out_status_r  <= res_status_r;
      out_removed_r <= res_removed_r;
      out_count_r   <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_entry_count   = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("list count above capacity");

  a_node_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fresh_r == count_r + stk_top_r))
    else $error("node accounting lost a node");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (k_r < count_r))
    else $error("walk ran past the list");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_DONE) |-> (out_removed_r == '0))
    else $error("failed request reports a removed word");

endmodule

// ----- rtl/lldq_node_mem.sv -----
module lldq_node_mem import lldq_pkg::*; #(
  parameter int DEPTH = 64,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  lldq_we_t           we,
  input  logic [IDX_W-1:0]   wr_val_addr,
  input  logic signed [31:0] wr_val,
  input  logic [IDX_W-1:0]   wr_nxt_addr,
  input  logic [IDX_W-1:0]   wr_nxt,
  input  logic [IDX_W-1:0]   wr_prv_addr,
  input  logic [IDX_W-1:0]   wr_prv,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic signed [31:0] rd_val,
  output logic [IDX_W-1:0]   rd_nxt,
  output logic [IDX_W-1:0]   rd_prv
);

  logic signed [31:0] val_mem [DEPTH];
  logic [IDX_W-1:0]   nxt_mem [DEPTH];
  logic [IDX_W-1:0]   prv_mem [DEPTH];

  // one shared read address, registered read data
  always_ff @(posedge clk) begin
    if (we.val) begin
      val_mem[wr_val_addr] <= wr_val;
    end
    if (we.nxt) begin
      nxt_mem[wr_nxt_addr] <= wr_nxt;
    end
    if (we.prv) begin
      prv_mem[wr_prv_addr] <= wr_prv;
    end
    rd_val <= val_mem[rd_addr];
    rd_nxt <= nxt_mem[rd_addr];
    rd_prv <= prv_mem[rd_addr];
  end

endmodule
